### rtl/core/ags_pkg.sv
package ags_pkg;

   // default number of calibration words after reset
   localparam int SAMPLE_COUNT_DEF = 128;

   // field widths
   localparam int BYTE_W    = 8;
   localparam int AXIS_W    = 12;
   localparam int OUT_W     = 16;
   localparam int MAG_W     = 16;
   localparam int FACTOR_W  = 16;
   localparam int WARMUP_W  = 8;
   localparam int SQ_W      = 24;
   localparam int SUM_W     = 24;
   localparam int WORK_W    = 32;
   localparam int UNIT_W    = 19;
   localparam int CONV_Q_W  = 16;
   localparam int STEP_W    = 5;

   // step counts of the shared unit
   localparam int SQRT_STEPS = MAG_W;
   localparam int CONV_STEPS = CONV_Q_W;

   // csr port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // register reset values
   localparam logic [FACTOR_W-1:0] SPREAD_RESET   = 16'd1440;
   localparam logic [FACTOR_W-1:0] FALLBACK_RESET = 16'd16448;
   localparam logic [WARMUP_W-1:0] WARMUP_RESET   = 8'd2;

   // saturation limits, signed Q0.16 (axis / gravity factor)
   localparam logic [OUT_W-1:0] SAT_POS = 16'h7FFF;
   localparam logic [OUT_W-1:0] SAT_NEG = 16'h8000;

   typedef enum logic [1:0] {
      REG_SPREAD_LIMIT = 2'd0,
      REG_FALLBACK     = 2'd1,
      REG_WARMUP       = 2'd2
   } ags_reg_type;

   typedef struct packed {
      logic [FACTOR_W-1:0] spread_limit;
      logic [FACTOR_W-1:0] fallback_gravity;
      logic [WARMUP_W-1:0] warmup_skip;
   } ags_cfg_type;

   typedef struct packed {
      logic              ge;
      logic [UNIT_W-1:0] diff;
   } ags_trial_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SQRT,
      ST_TRACK,
      ST_AVG_DIV,
      ST_DECIDE,
      ST_CONV_LOAD,
      ST_CONV_DIV,
      ST_FINISH
   } ags_state_type;

endpackage

### rtl/core/accel_gravity_calibrate_scale.sv
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_ready  | six raw sensor bytes
// rsp     | out       | rsp_valid / rsp_ready  | kind, accel x/y/z, factor, flags
// csr     | in        | psel, penable, pwrite  | spread limit, fallback, warm-up
//
// a calibration word passes through accept, 3 squaring steps, 16 root steps and an update;
// the last one adds an average step (reciprocal multiply), a decide step and an output step
// a scaling word runs accept, then per axis a load step plus 16 divide
// steps, then output; the divide is skipped when the axis saturates or the factor is zero
// root and divide steps share the 19-bit compare-subtract unit
// synchronous active-high reset; the output register lets a new word in while
// an earlier result waits, so the core stalls only when a second result is ready
module accel_gravity_calibrate_scale #(
   parameter int SAMPLE_COUNT = ags_pkg::SAMPLE_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request words
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ags_pkg::BYTE_W-1:0]          req_x_low_byte,
   input  logic [ags_pkg::BYTE_W-1:0]          req_x_high_byte,
   input  logic [ags_pkg::BYTE_W-1:0]          req_y_low_byte,
   input  logic [ags_pkg::BYTE_W-1:0]          req_y_high_byte,
   input  logic [ags_pkg::BYTE_W-1:0]          req_z_low_byte,
   input  logic [ags_pkg::BYTE_W-1:0]          req_z_high_byte,
   // response words
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_result_kind,
   output logic signed [ags_pkg::OUT_W-1:0]    rsp_accel_x,
   output logic signed [ags_pkg::OUT_W-1:0]    rsp_accel_y,
   output logic signed [ags_pkg::OUT_W-1:0]    rsp_accel_z,
   output logic [ags_pkg::FACTOR_W-1:0]        rsp_gravity_factor,
   output logic                                rsp_used_fallback,
   output logic                                rsp_saturated,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ags_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ags_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ags_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int IDX_W = $clog2(SAMPLE_COUNT + 1);
   localparam logic [IDX_W-1:0] IDX_DONE = IDX_W'(SAMPLE_COUNT);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLE_COUNT - 1);
   localparam logic [ags_pkg::STEP_W-1:0] SQRT_LAST = ags_pkg::STEP_W'(ags_pkg::SQRT_STEPS - 1);
   localparam logic [ags_pkg::STEP_W-1:0] CONV_LAST = ags_pkg::STEP_W'(ags_pkg::CONV_STEPS - 1);
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // average as sum * ceil(2^shift / count) >> shift, exact for every 24-bit sum
   localparam int AVG_SHIFT = ags_pkg::SUM_W + $clog2(SAMPLE_COUNT);
   localparam int RECIP_W   = ags_pkg::SUM_W + 2;
   localparam int PROD_W    = ags_pkg::SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

   // configuration registers
   ags_pkg::ags_cfg_type cfg;

   ags_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer state
   ags_pkg::ags_state_type state_ff, state_in;

   // unpacked axes of the word at work
   logic signed [ags_pkg::AXIS_W-1:0] ax_x_ff, ax_x_in;
   logic signed [ags_pkg::AXIS_W-1:0] ax_y_ff, ax_y_in;
   logic signed [ags_pkg::AXIS_W-1:0] ax_z_ff, ax_z_in;
   logic [1:0]                        axis_ff, axis_in;

   // shared work registers
   logic [ags_pkg::SQ_W-1:0]   sq_ff, sq_in;
   logic [ags_pkg::WORK_W-1:0] num_ff, num_in;
   logic [ags_pkg::UNIT_W-1:0] rem_ff, rem_in;
   logic [ags_pkg::MAG_W-1:0]  root_ff, root_in;
   logic [ags_pkg::STEP_W-1:0] step_ff, step_in;

   // calibration state
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [ags_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [ags_pkg::MAG_W-1:0]    min_ff, min_in;
   logic [ags_pkg::MAG_W-1:0]    max_ff, max_in;
   logic [ags_pkg::FACTOR_W-1:0] factor_ff, factor_in;
   logic                         fb_ff, fb_in;

   // result being built
   logic                      res_kind_ff, res_kind_in;
   logic [ags_pkg::OUT_W-1:0] res_x_ff, res_x_in;
   logic [ags_pkg::OUT_W-1:0] res_y_ff, res_y_in;
   logic [ags_pkg::OUT_W-1:0] res_z_ff, res_z_in;
   logic                      res_sat_ff, res_sat_in;

   // output register
   logic                         out_valid_ff, out_valid_in;
   logic                         out_kind_ff, out_kind_in;
   logic [ags_pkg::OUT_W-1:0]    out_x_ff, out_x_in;
   logic [ags_pkg::OUT_W-1:0]    out_y_ff, out_y_in;
   logic [ags_pkg::OUT_W-1:0]    out_z_ff, out_z_in;
   logic [ags_pkg::FACTOR_W-1:0] out_factor_ff, out_factor_in;
   logic                         out_fb_ff, out_fb_in;
   logic                         out_sat_ff, out_sat_in;

   // combinational helpers
   logic                              req_take;
   logic                              calibrating;
   logic                              out_free;
   logic signed [ags_pkg::AXIS_W-1:0] new_x, new_y, new_z;
   logic signed [ags_pkg::AXIS_W-1:0] sel_axis;
   logic [ags_pkg::AXIS_W-1:0]        abs_axis;
   logic signed [2*ags_pkg::AXIS_W-1:0] prod;
   logic [ags_pkg::SQ_W-1:0]          prod_u;
   logic [ags_pkg::SQ_W-1:0]          sq_sum;
   logic [ags_pkg::SUM_W-1:0]         sum_next;
   logic [PROD_W-1:0]                 avg_prod;
   logic [ags_pkg::MAG_W-1:0]         spread;
   logic [ags_pkg::FACTOR_W-1:0]      factor_new;
   logic [ags_pkg::CONV_Q_W-1:0]      quot;
   logic [ags_pkg::OUT_W-1:0]         res_val;
   logic                              res_we;
   logic                              res_sat_new;
   logic [ags_pkg::UNIT_W-1:0]        trial_a, trial_b;
   ags_pkg::ags_trial_type            trial_res;

   ags_trial_sub u_trial (
      .trial_a   (trial_a),
      .trial_b   (trial_b),
      .trial_res (trial_res)
   );

   assign req_ready   = (state_ff == ags_pkg::ST_IDLE);
   assign req_take    = req_valid & req_ready;
   assign calibrating = (idx_ff < IDX_DONE);
   assign out_free    = ~out_valid_ff | rsp_ready;

   // left-justified 12-bit data: high byte and the upper nibble of the low byte
   assign new_x = {req_x_high_byte, req_x_low_byte[7:4]};
   assign new_y = {req_y_high_byte, req_y_low_byte[7:4]};
   assign new_z = {req_z_high_byte, req_z_low_byte[7:4]};

   always_comb begin
      unique case (axis_ff)
         AXIS_X:  sel_axis = ax_x_ff;
         AXIS_Y:  sel_axis = ax_y_ff;
         default: sel_axis = ax_z_ff;
      endcase
   end

   assign abs_axis = sel_axis[ags_pkg::AXIS_W-1] ? ags_pkg::AXIS_W'(-sel_axis)
                                                  : ags_pkg::AXIS_W'(sel_axis);
   assign prod     = sel_axis * sel_axis;
   assign prod_u   = ags_pkg::SQ_W'(prod);
   assign sq_sum   = sq_ff + prod_u;
   assign sum_next = sum_ff + ags_pkg::SUM_W'(root_ff);

   // 24 by 26 bit reciprocal product of the final sum
   assign avg_prod = PROD_W'(sum_ff) * PROD_W'(AVG_RECIP);

   // spread is zero when nothing was tracked (max still below min)
   assign spread     = (max_ff >= min_ff) ? (max_ff - min_ff) : '0;
   assign factor_new = (spread < cfg.spread_limit) ? num_ff[ags_pkg::FACTOR_W-1:0]
                                                   : cfg.fallback_gravity;
   assign quot       = {num_ff[ags_pkg::CONV_Q_W-2:0], trial_res.ge};

   // operand select for the shared unit
   always_comb begin
      unique case (state_ff)
         ags_pkg::ST_SQRT: begin
            // bring down two radicand bits, trial is 4*root + 1
            trial_a = {rem_ff[ags_pkg::UNIT_W-3:0], num_ff[ags_pkg::WORK_W-1 -: 2]};
            trial_b = ags_pkg::UNIT_W'({root_ff, 2'b01});
         end
         ags_pkg::ST_CONV_DIV: begin
            trial_a = {rem_ff[ags_pkg::UNIT_W-2:0], num_ff[ags_pkg::WORK_W-1]};
            trial_b = ags_pkg::UNIT_W'(factor_ff);
         end
         ags_pkg::ST_CONV_LOAD: begin
            // axis at or above factor means a quotient of 2^16 or more
            trial_a = ags_pkg::UNIT_W'(abs_axis);
            trial_b = ags_pkg::UNIT_W'(factor_ff);
         end
         default: begin
            trial_a = '0;
            trial_b = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ags_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = calibrating ? ags_pkg::ST_SQUARE : ags_pkg::ST_CONV_LOAD;
            end
         end
         ags_pkg::ST_SQUARE: begin
            if (axis_ff == AXIS_Z) state_in = ags_pkg::ST_SQRT;
         end
         ags_pkg::ST_SQRT: begin
            if (step_ff == '0) state_in = ags_pkg::ST_TRACK;
         end
         ags_pkg::ST_TRACK: begin
            state_in = (idx_ff == IDX_LAST) ? ags_pkg::ST_AVG_DIV : ags_pkg::ST_IDLE;
         end
         ags_pkg::ST_AVG_DIV: begin
            state_in = ags_pkg::ST_DECIDE;
         end
         ags_pkg::ST_DECIDE: begin
            state_in = ags_pkg::ST_FINISH;
         end
         ags_pkg::ST_CONV_LOAD: begin
            if ((factor_ff != '0) && !trial_res.ge) begin
               state_in = ags_pkg::ST_CONV_DIV;
            end else if (axis_ff == AXIS_Z) begin
               state_in = ags_pkg::ST_FINISH;
            end
         end
         ags_pkg::ST_CONV_DIV: begin
            if (step_ff == '0) begin
               state_in = (axis_ff == AXIS_Z) ? ags_pkg::ST_FINISH : ags_pkg::ST_CONV_LOAD;
            end
         end
         ags_pkg::ST_FINISH: begin
            if (out_free) state_in = ags_pkg::ST_IDLE;
         end
         default: begin
            state_in = ags_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      ax_x_in     = ax_x_ff;
      ax_y_in     = ax_y_ff;
      ax_z_in     = ax_z_ff;
      axis_in     = axis_ff;
      sq_in       = sq_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      step_in     = step_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      factor_in   = factor_ff;
      fb_in       = fb_ff;
      res_kind_in = res_kind_ff;
      res_x_in    = res_x_ff;
      res_y_in    = res_y_ff;
      res_z_in    = res_z_ff;
      res_sat_in  = res_sat_ff;
      res_val     = '0;
      res_we      = 1'b0;
      res_sat_new = 1'b0;

      unique case (state_ff)
         ags_pkg::ST_IDLE: begin
            if (req_take) begin
               ax_x_in     = new_x;
               ax_y_in     = new_y;
               ax_z_in     = new_z;
               axis_in     = AXIS_X;
               sq_in       = '0;
               res_kind_in = ~calibrating;
               res_sat_in  = 1'b0;
            end
         end
         ags_pkg::ST_SQUARE: begin
            sq_in   = sq_sum;
            axis_in = axis_ff + 2'd1;
            if (axis_ff == AXIS_Z) begin
               num_in  = {sq_sum, {(ags_pkg::WORK_W - ags_pkg::SQ_W){1'b0}}};
               rem_in  = '0;
               root_in = '0;
               step_in = SQRT_LAST;
            end
         end
         ags_pkg::ST_SQRT: begin
            num_in  = {num_ff[ags_pkg::WORK_W-3:0], 2'b00};
            rem_in  = trial_res.ge ? trial_res.diff : trial_a;
            root_in = {root_ff[ags_pkg::MAG_W-2:0], trial_res.ge};
            step_in = step_ff - 1'b1;
         end
         ags_pkg::ST_TRACK: begin
            sum_in = sum_next;
            if (32'(idx_ff) >= 32'(cfg.warmup_skip)) begin
               if (root_ff <= min_ff) min_in = root_ff;
               if (root_ff > max_ff)  max_in = root_ff;
            end
            idx_in = idx_ff + 1'b1;
         end
         ags_pkg::ST_AVG_DIV: begin
            // quotient of the final sum by the sample count
            num_in = ags_pkg::WORK_W'(avg_prod >> AVG_SHIFT);
         end
         ags_pkg::ST_DECIDE: begin
            factor_in   = factor_new;
            fb_in       = ~(spread < cfg.spread_limit);
            res_kind_in = 1'b0;
            res_x_in    = '0;
            res_y_in    = '0;
            res_z_in    = '0;
            res_sat_in  = (factor_new == '0);
         end
         ags_pkg::ST_CONV_LOAD: begin
            if (factor_ff == '0) begin
               // zero factor: saturate by sign
               res_we      = 1'b1;
               res_sat_new = 1'b1;
               if (sel_axis == '0) begin
                  res_val = '0;
               end else begin
                  res_val = sel_axis[ags_pkg::AXIS_W-1] ? ags_pkg::SAT_NEG : ags_pkg::SAT_POS;
               end
               axis_in = axis_ff + 2'd1;
            end else if (trial_res.ge) begin
               res_we      = 1'b1;
               res_sat_new = 1'b1;
               res_val     = sel_axis[ags_pkg::AXIS_W-1] ? ags_pkg::SAT_NEG : ags_pkg::SAT_POS;
               axis_in     = axis_ff + 2'd1;
            end else begin
               // remainder starts at |axis|, the low 16 dividend bits are zero
               num_in  = '0;
               rem_in  = ags_pkg::UNIT_W'(abs_axis);
               step_in = CONV_LAST;
            end
         end
         ags_pkg::ST_CONV_DIV: begin
            num_in  = {num_ff[ags_pkg::WORK_W-2:0], trial_res.ge};
            rem_in  = trial_res.ge ? trial_res.diff : trial_a;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               res_we  = 1'b1;
               axis_in = axis_ff + 2'd1;
               if (sel_axis[ags_pkg::AXIS_W-1]) begin
                  if (quot > ags_pkg::SAT_NEG) begin
                     res_val     = ags_pkg::SAT_NEG;
                     res_sat_new = 1'b1;
                  end else begin
                     res_val = ags_pkg::OUT_W'(-quot);
                  end
               end else begin
                  if (quot > ags_pkg::SAT_POS) begin
                     res_val     = ags_pkg::SAT_POS;
                     res_sat_new = 1'b1;
                  end else begin
                     res_val = quot;
                  end
               end
            end
         end
         ags_pkg::ST_FINISH: begin
            axis_in = AXIS_X;
         end
         default: begin
            axis_in = AXIS_X;
         end
      endcase

      if (res_we) begin
         res_sat_in = res_sat_ff | res_sat_new;
         unique case (axis_ff)
            AXIS_X:  res_x_in = res_val;
            AXIS_Y:  res_y_in = res_val;
            default: res_z_in = res_val;
         endcase
      end
   end

   // output register: loaded from the finished result, cleared when taken
   always_comb begin
      out_valid_in  = out_valid_ff & ~rsp_ready;
      out_kind_in   = out_kind_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_z_in      = out_z_ff;
      out_factor_in = out_factor_ff;
      out_fb_in     = out_fb_ff;
      out_sat_in    = out_sat_ff;
      if ((state_ff == ags_pkg::ST_FINISH) && out_free) begin
         out_valid_in  = 1'b1;
         out_kind_in   = res_kind_ff;
         out_x_in      = res_x_ff;
         out_y_in      = res_y_ff;
         out_z_in      = res_z_ff;
         out_factor_in = factor_ff;
         out_fb_in     = fb_ff;
         out_sat_in    = res_sat_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_result_kind    = out_kind_ff;
   assign rsp_accel_x        = out_x_ff;
   assign rsp_accel_y        = out_y_ff;
   assign rsp_accel_z        = out_z_ff;
   assign rsp_gravity_factor = out_factor_ff;
   assign rsp_used_fallback  = out_fb_ff;
   assign rsp_saturated      = out_sat_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ags_pkg::ST_IDLE;
         axis_ff      <= AXIS_X;
         step_ff      <= '0;
         idx_ff       <= '0;
         sum_ff       <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         factor_ff    <= ags_pkg::FALLBACK_RESET;
         fb_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         factor_ff    <= factor_in;
         fb_ff        <= fb_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ax_x_ff       <= ax_x_in;
      ax_y_ff       <= ax_y_in;
      ax_z_ff       <= ax_z_in;
      sq_ff         <= sq_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      res_kind_ff   <= res_kind_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_z_ff      <= res_z_in;
      res_sat_ff    <= res_sat_in;
      out_kind_ff   <= out_kind_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_z_ff      <= out_z_in;
      out_factor_ff <= out_factor_in;
      out_fb_ff     <= out_fb_in;
      out_sat_ff    <= out_sat_in;
   end

   // no result can appear before calibration is complete
   a_rsp_after_cal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (idx_ff == IDX_DONE))
      else $error("response before calibration finished");

   // sample counter never runs past the calibration length
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_DONE)
      else $error("sample index overrun");

   // a calibration result carries zero axes
   a_cal_axes_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result_kind) |->
         (rsp_accel_x == '0 && rsp_accel_y == '0 && rsp_accel_z == '0))
      else $error("calibration result with nonzero axes");

   // an accepted word always starts work
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ags_pkg::ST_SQUARE || state_ff == ags_pkg::ST_CONV_LOAD))
      else $error("accepted word did not start");

   // a stalled output word is not overwritten by a new result
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_accel_x) && $stable(rsp_saturated)))
      else $error("pending result overwritten");

endmodule

### rtl/core/ags_csr.sv
module ags_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ags_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ags_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ags_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output ags_pkg::ags_cfg_type              cfg
);

   ags_pkg::ags_cfg_type cfg_ff;
   ags_pkg::ags_cfg_type cfg_in;
   ags_pkg::ags_reg_type reg_sel;
   logic                 wr_en;

   assign reg_sel    = ags_pkg::ags_reg_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            ags_pkg::REG_SPREAD_LIMIT: begin
               cfg_in.spread_limit = csr_pwdata[ags_pkg::FACTOR_W-1:0];
            end
            ags_pkg::REG_FALLBACK: begin
               cfg_in.fallback_gravity = csr_pwdata[ags_pkg::FACTOR_W-1:0];
            end
            ags_pkg::REG_WARMUP: begin
               cfg_in.warmup_skip = csr_pwdata[ags_pkg::WARMUP_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         ags_pkg::REG_SPREAD_LIMIT: begin
            csr_prdata = ags_pkg::CSR_DATA_W'(cfg_ff.spread_limit);
         end
         ags_pkg::REG_FALLBACK: begin
            csr_prdata = ags_pkg::CSR_DATA_W'(cfg_ff.fallback_gravity);
         end
         ags_pkg::REG_WARMUP: begin
            csr_prdata = ags_pkg::CSR_DATA_W'(cfg_ff.warmup_skip);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spread_limit     <= ags_pkg::SPREAD_RESET;
         cfg_ff.fallback_gravity <= ags_pkg::FALLBACK_RESET;
         cfg_ff.warmup_skip      <= ags_pkg::WARMUP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/ags_trial_sub.sv
module ags_trial_sub (
   input  logic [ags_pkg::UNIT_W-1:0] trial_a,
   input  logic [ags_pkg::UNIT_W-1:0] trial_b,
   output ags_pkg::ags_trial_type     trial_res
);

   // one compare and subtract, shared by root and scaling steps
   logic [ags_pkg::UNIT_W:0] diff_ext;

   assign diff_ext       = {1'b0, trial_a} - {1'b0, trial_b};
   assign trial_res.ge   = ~diff_ext[ags_pkg::UNIT_W];
   assign trial_res.diff = diff_ext[ags_pkg::UNIT_W-1:0];

endmodule
